>>> design/twfir_pkg.sv
// Shared types, constants and coefficient ROM for the twist-correction FIR.
`timescale 1ns / 1ps

package twfir_pkg;

  localparam int TAP_COUNT  = 9;
  localparam int HIST       = TAP_COUNT - 1;
  localparam int SET_COUNT  = 19;
  localparam int TWIST_MIN  = -6;
  localparam int TWIST_MAX  = 12;
  localparam int TAP_W      = $clog2(TAP_COUNT);
  localparam int HIST_W     = $clog2(HIST);
  localparam int ROW_W      = $clog2(SET_COUNT);
  localparam int SAMPLE_W   = 16;
  localparam int TWIST_W    = 5;
  localparam int ACC_W      = 32;
  localparam int FRAC_BITS  = 15;

  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAP_COUNT - 1);

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;     // capture coef * data into the product register
    logic acc_en;     // add the product register into the accumulator
    logic acc_first;  // start a fresh sum instead of adding to the old one
  } mac_ctrl_t;

  // One row per twist setting, -6 dB first.
  localparam logic signed [SAMPLE_W-1:0] COEF_ROM [SET_COUNT][TAP_COUNT] = '{
    '{  16'sd176,   -16'sd812, -16'sd3916, -16'sd7586, 16'sd23536,
       -16'sd7586, -16'sd3916,  -16'sd812,   16'sd176 },
    '{  16'sd121,   -16'sd957, -16'sd3959, -16'sd7383, 16'sd23871,
       -16'sd7383, -16'sd3959,  -16'sd957,   16'sd121 },
    '{   16'sd56,  -16'sd1110, -16'sd3987, -16'sd7141, 16'sd24254,
       -16'sd7141, -16'sd3987, -16'sd1110,    16'sd56 },
    '{  -16'sd19,  -16'sd1268, -16'sd3994, -16'sd6856, 16'sd24688,
       -16'sd6856, -16'sd3994, -16'sd1268,   -16'sd19 },
    '{ -16'sd104,  -16'sd1424, -16'sd3968, -16'sd6516, 16'sd25182,
       -16'sd6516, -16'sd3968, -16'sd1424,  -16'sd104 },
    '{ -16'sd196,  -16'sd1565, -16'sd3896, -16'sd6114, 16'sd25742,
       -16'sd6114, -16'sd3896, -16'sd1565,  -16'sd196 },
    '{ -16'sd288,  -16'sd1676, -16'sd3761, -16'sd5642, 16'sd26370,
       -16'sd5642, -16'sd3761, -16'sd1676,  -16'sd288 },
    '{ -16'sd370,  -16'sd1735, -16'sd3545, -16'sd5088, 16'sd27075,
       -16'sd5088, -16'sd3545, -16'sd1735,  -16'sd370 },
    '{ -16'sd432,  -16'sd1715, -16'sd3220, -16'sd4427, 16'sd27880,
       -16'sd4427, -16'sd3220, -16'sd1715,  -16'sd432 },
    '{ -16'sd452,  -16'sd1582, -16'sd2759, -16'sd3646, 16'sd28792,
       -16'sd3646, -16'sd2759, -16'sd1582,  -16'sd452 },
    '{ -16'sd408,  -16'sd1295, -16'sd2123, -16'sd2710, 16'sd29846,
       -16'sd2710, -16'sd2123, -16'sd1295,  -16'sd408 },
    '{ -16'sd268,   -16'sd795, -16'sd1244, -16'sd1546, 16'sd31116,
       -16'sd1546, -16'sd1244,  -16'sd795,  -16'sd268 },
    '{    16'sd0,      16'sd0,     16'sd0,     16'sd0, 16'sd32767,
           16'sd0,     16'sd0,     16'sd0,     16'sd0 },
    '{ -16'sd419,   -16'sd177,  16'sd3316,  16'sd8650, 16'sd11278,
        16'sd8650,  16'sd3316,  -16'sd177,  -16'sd419 },
    '{  -16'sd90,   16'sd1033,  16'sd3975,  16'sd7267,  16'sd8711,
        16'sd7267,  16'sd3975,  16'sd1033,   -16'sd90 },
    '{  16'sd292,   16'sd1680,  16'sd3752,  16'sd5615,  16'sd6362,
        16'sd5615,  16'sd3752,  16'sd1680,   16'sd292 },
    '{  16'sd917,   16'sd3024,  16'sd5131,  16'sd6684,  16'sd7255,
        16'sd6684,  16'sd5131,  16'sd3024,   16'sd917 },
    '{ 16'sd1620,   16'sd3339,  16'sd4925,  16'sd6042,  16'sd6444,
        16'sd6042,  16'sd4925,  16'sd3339,  16'sd1620 },
    '{ 16'sd2161,   16'sd3472,  16'sd4605,  16'sd5373,  16'sd5644,
        16'sd5373,  16'sd4605,  16'sd3472,  16'sd2161 }
  };

  // Clamp the twist setting and turn it into a ROM row.
  function automatic logic [ROW_W-1:0] twist_row(input logic signed [TWIST_W-1:0] twist);
    logic [ROW_W-1:0] row;
    if (twist < TWIST_W'(TWIST_MIN)) begin
      row = '0;
    end else if (twist > TWIST_W'(TWIST_MAX)) begin
      row = ROW_W'(SET_COUNT - 1);
    end else begin
      row = ROW_W'(twist - TWIST_W'(TWIST_MIN));
    end
    return row;
  endfunction

endpackage

>>> design/twist_fir_q15_9tap.sv
// Top level of the nine-tap Q15 twist-correction FIR filter.
`timescale 1ns / 1ps

// Twist-correction FIR for 1200/2200 Hz tone audio. Each accepted input
// word is one signed Q15 sample; exactly one filtered Q15 output word comes
// back per input, saturated to 16 bits. The filter keeps the last eight
// samples (cleared by reset) and convolves them plus the new sample with one
// of 19 symmetric 9-tap coefficient sets, picked by twist_db (-6..+12 dB,
// values outside that range clamp to the nearest end). Writing twist_db via
// cfg_wr_en/cfg_wr_data takes effect on the next sample and leaves the
// sample history alone; write it only while no sample is in flight.
// One multiplier is shared across all nine taps, one tap per cycle,
// followed by a drain step that folds the last product into the
// accumulator and a result step that loads the output register. The
// result becomes valid and in_ready returns at the same edge, so a new
// input waits until the last result is loaded. A finished word parks
// in the output register, and the next input is taken while it waits; a
// second result only stalls if the first still has not been taken.
module twist_fir_q15_9tap (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [twfir_pkg::TWIST_W-1:0]         cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [twfir_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [twfir_pkg::SAMPLE_W-1:0] sample_out
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_RESULT
  } state_t;

  state_t                                state;
  logic [twfir_pkg::TAP_W-1:0]           tap;
  logic signed [twfir_pkg::TWIST_W-1:0]  twist_db;
  logic signed [twfir_pkg::SAMPLE_W-1:0] sample_reg;
  logic signed [twfir_pkg::SAMPLE_W-1:0] delay_line [twfir_pkg::HIST];
  logic [twfir_pkg::ROW_W-1:0]           row;
  logic [twfir_pkg::HIST_W-1:0]          hist_idx;
  logic signed [twfir_pkg::SAMPLE_W-1:0] tap_data;
  logic signed [twfir_pkg::SAMPLE_W-1:0] tap_coef;
  logic signed [twfir_pkg::SAMPLE_W-1:0] mac_result;
  twfir_pkg::mac_ctrl_t                  mac_ctrl;
  logic                                  out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Tap 0 is the new sample, tap k is the sample k words back.
  assign row      = twfir_pkg::twist_row(twist_db);
  assign hist_idx = tap[twfir_pkg::HIST_W-1:0] - twfir_pkg::HIST_W'(1);
  assign tap_data = (tap == '0) ? sample_reg : delay_line[hist_idx];
  assign tap_coef = twfir_pkg::COEF_ROM[row][tap];

  // Product is registered, so each product is accumulated in the cycle after its multiply.
  always_comb begin
    mac_ctrl.mul_en    = (state == S_MAC);
    mac_ctrl.acc_en    = ((state == S_MAC) && (tap != '0)) || (state == S_DRAIN);
    mac_ctrl.acc_first = (state == S_MAC) && (tap == twfir_pkg::TAP_W'(1));
  end

  twfir_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .coef   (tap_coef),
    .data   (tap_data),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap       <= '0;
      twist_db  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < twfir_pkg::HIST; i++) begin
        delay_line[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        twist_db <= cfg_wr_data;
      end
      // In the result step the output register is reloaded below instead.
      if (out_valid && out_ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_reg <= sample_in;
            tap        <= '0;
            state      <= S_MAC;
          end
        end
        S_MAC: begin
          if (tap == twfir_pkg::LAST_TAP) begin
            state <= S_DRAIN;
          end else begin
            tap <= tap + twfir_pkg::TAP_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          // Hold here until the output register frees up.
          if (out_free) begin
            sample_out    <= mac_result;
            out_valid     <= 1'b1;
            delay_line[0] <= sample_reg;
            for (int i = 1; i < twfir_pkg::HIST; i++) begin
              delay_line[i] <= delay_line[i-1];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sequencer checks.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MAC) && (tap == '0))
    else $error("accepted word did not start the tap sweep");

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    tap <= twfir_pkg::LAST_TAP)
    else $error("tap counter out of range");

  a_last_tap_drains: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) && (tap == twfir_pkg::LAST_TAP) |=> (state == S_DRAIN))
    else $error("last tap did not move to drain");

  a_out_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_RESULT))
    else $error("output word raised outside the result step");

endmodule

>>> design/twfir_mac.sv
// Shared multiply-accumulate unit with Q15 shift and 16-bit saturation.
`timescale 1ns / 1ps

module twfir_mac (
  input  logic                                clk,
  input  twfir_pkg::mac_ctrl_t                ctrl,
  input  logic signed [twfir_pkg::SAMPLE_W-1:0] coef,
  input  logic signed [twfir_pkg::SAMPLE_W-1:0] data,
  output logic signed [twfir_pkg::SAMPLE_W-1:0] result
);

  logic signed [twfir_pkg::ACC_W-1:0]                       prod;
  logic signed [twfir_pkg::ACC_W-1:0]                       acc;
  logic signed [twfir_pkg::ACC_W-twfir_pkg::FRAC_BITS-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= coef * data;
    end
    if (ctrl.acc_en) begin
      acc <= (ctrl.acc_first ? '0 : acc) + prod;
    end
  end

  // Floor shift by the fraction width is just dropping the low bits.
  assign shifted = acc[twfir_pkg::ACC_W-1:twfir_pkg::FRAC_BITS];

  always_comb begin
    if (shifted[$bits(shifted)-1] == shifted[twfir_pkg::SAMPLE_W-1]) begin
      result = shifted[twfir_pkg::SAMPLE_W-1:0];
    end else if (shifted[$bits(shifted)-1]) begin
      result = {1'b1, {(twfir_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(twfir_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

endmodule
